/* rtl/camera_point_to_world_frame_unit_assert.svh */
// Assertion macros for the camera-to-world frame unit.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef CAMERA_POINT_TO_WORLD_FRAME_UNIT_ASSERT_SVH
`define CAMERA_POINT_TO_WORLD_FRAME_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cptw_pkg.sv */
// Shared types and constants for the camera-to-world frame unit.
// No dependencies; used by cptw_quat_mat and the top level.
package cptw_pkg;

	// field widths
	localparam int PosW     = 32;
	localparam int QuatW    = 16;
	localparam int CoefW    = 16;
	localparam int RowW     = 3 * CoefW;
	localparam int CamW     = PosW + 1;
	localparam int VehPW    = 39;
	localparam int MpW      = CoefW + CamW;
	localparam int AccW     = MpW + 2;
	localparam int QProdW   = 2 * QuatW;
	localparam int QSumW    = QProdW + 2;
	localparam int CfgIdxW  = 3;

	localparam int CoefFracBitsDef = 14;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CfgRotRow0 = 3'd0,
		CfgRotRow1 = 3'd1,
		CfgRotRow2 = 3'd2,
		CfgCamOffX = 3'd3,
		CfgCamOffY = 3'd4,
		CfgCamOffZ = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic signed [PosW-1:0]  marker_x;
		logic signed [PosW-1:0]  marker_y;
		logic signed [PosW-1:0]  marker_z;
		logic signed [QuatW-1:0] quat_w;
		logic signed [QuatW-1:0] quat_x;
		logic signed [QuatW-1:0] quat_y;
		logic signed [QuatW-1:0] quat_z;
		logic signed [PosW-1:0]  veh_x;
		logic signed [PosW-1:0]  veh_y;
		logic signed [PosW-1:0]  veh_z;
	} in_item_t;

	typedef struct packed {
		logic signed [PosW-1:0] world_x;
		logic signed [PosW-1:0] world_y;
		logic signed [PosW-1:0] world_z;
		logic                   overflow;
	} out_item_t;

	// per-stage advance enables of the pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_en_t;

endpackage

/* rtl/cptw_quat_mat.sv */
// Quaternion to rotation matrix, two pipeline stages (products, then sums and rounding).
// Depends on cptw_pkg for widths and the enable struct.
module cptw_quat_mat #(
	parameter int COEF_FRAC_BITS = cptw_pkg::CoefFracBitsDef
) (
	input  logic                                  clk,
	input  cptw_pkg::pipe_en_t                    en,
	input  logic signed [cptw_pkg::QuatW-1:0]     qw,
	input  logic signed [cptw_pkg::QuatW-1:0]     qx,
	input  logic signed [cptw_pkg::QuatW-1:0]     qy,
	input  logic signed [cptw_pkg::QuatW-1:0]     qz,
	output logic [8:0][cptw_pkg::QSumW-COEF_FRAC_BITS-1:0] r_s2
);
	import cptw_pkg::*;

	localparam int RW = QSumW - COEF_FRAC_BITS;
	localparam logic signed [QSumW-1:0] QOne  = QSumW'(1) <<< (2 * COEF_FRAC_BITS);
	localparam logic signed [QSumW-1:0] QHalf = QSumW'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [QProdW-1:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [QProdW-1:0] pwx_s1, pwy_s1, pwz_s1;
	logic signed [QSumW-1:0]  t [9];
	logic signed [QSumW-1:0]  tr [9];

	// stage 1: the nine distinct quaternion products
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			pxx_s1 <= qx * qx;
			pyy_s1 <= qy * qy;
			pzz_s1 <= qz * qz;
			pxy_s1 <= qx * qy;
			pxz_s1 <= qx * qz;
			pyz_s1 <= qy * qz;
			pwx_s1 <= qw * qx;
			pwy_s1 <= qw * qy;
			pwz_s1 <= qw * qz;
		end
	end

	// unnormalized matrix entries with 2C fraction bits, row major
	always_comb begin
		t[0] = QOne - ((QSumW'(pyy_s1) + QSumW'(pzz_s1)) <<< 1);
		t[1] = (QSumW'(pxy_s1) - QSumW'(pwz_s1)) <<< 1;
		t[2] = (QSumW'(pxz_s1) + QSumW'(pwy_s1)) <<< 1;
		t[3] = (QSumW'(pxy_s1) + QSumW'(pwz_s1)) <<< 1;
		t[4] = QOne - ((QSumW'(pxx_s1) + QSumW'(pzz_s1)) <<< 1);
		t[5] = (QSumW'(pyz_s1) - QSumW'(pwx_s1)) <<< 1;
		t[6] = (QSumW'(pxz_s1) - QSumW'(pwy_s1)) <<< 1;
		t[7] = (QSumW'(pyz_s1) + QSumW'(pwx_s1)) <<< 1;
		t[8] = QOne - ((QSumW'(pxx_s1) + QSumW'(pyy_s1)) <<< 1);
		// round half up to C fraction bits
		for (int k = 0; k < 9; k++) begin
			tr[k] = (t[k] + QHalf) >>> COEF_FRAC_BITS;
		end
	end

	// stage 2: rounded entries
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int k = 0; k < 9; k++) begin
				r_s2[k] <= tr[k][RW-1:0];
			end
		end
	end

endmodule

/* rtl/camera_point_to_world_frame_unit.sv */
// Camera-to-world frame unit: top level, config registers and the point pipeline.
// Depends on cptw_pkg, cptw_quat_mat and camera_point_to_world_frame_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one marker position in
//   camera coordinates plus the vehicle pose per request. Output channel
//   (out_valid/out_stall/out_data) returns one world position per request,
//   saturated to 32 bits, with overflow set when any coordinate clamped.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   camera-to-vehicle matrix rows and camera offset; cfg_ready is always
//   high, indexes above 5 are dropped. Write config only while idle.
//   An accepted request passes stage registers 1 to 5 to reach out_valid; one
//   request per cycle is accepted while in_stall is low, set by the five-stage
//   pipeline with one multiplier rank in each of stages 1, 2 and 4. Stalls are
//   absorbed stage by stage: empty stages keep filling, so in_stall rises only
//   when all five stages hold requests and out_stall is high. Reset empties
//   the pipeline and loads an identity matrix and zero offset.
module camera_point_to_world_frame_unit #(
	parameter int COEF_FRAC_BITS = cptw_pkg::CoefFracBitsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  cptw_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output cptw_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cptw_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [cptw_pkg::RowW-1:0]       cfg_data
);
	import cptw_pkg::*;

	localparam int RW  = QSumW - COEF_FRAC_BITS;
	localparam int RpW = RW + VehPW;
	localparam int SW  = RpW + 2;
	localparam logic signed [AccW-1:0] AHalf = AccW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [AccW-1:0] VHi   = (AccW'(1) <<< (VehPW - 1)) - AccW'(1);
	localparam logic signed [AccW-1:0] VLo   = -VHi - AccW'(1);
	localparam logic signed [SW-1:0]   SHalf = SW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [SW-1:0]   WHi   = (SW'(1) <<< (PosW - 1)) - SW'(1);
	localparam logic signed [SW-1:0]   WLo   = -WHi - SW'(1);

	// configuration registers
	logic [RowW-1:0]        rot_row_q [3];
	logic signed [PosW-1:0] cam_off_q [3];

	// pipeline control
	pipe_en_t en;
	logic     v_s1, v_s2, v_s3, v_s4, v_s5;

	// payload stages
	logic signed [CamW-1:0]  cam_s1 [3];
	logic signed [PosW-1:0]  veh_s1 [3], veh_s2 [3], veh_s3 [3], veh_s4 [3];
	logic signed [MpW-1:0]   mp_s2 [3][3];
	logic [8:0][RW-1:0]      r_s2, r_s3;
	logic signed [VehPW-1:0] vp_s3 [3];
	logic                    vovf_s3, vovf_s4;
	logic signed [RpW-1:0]   rp_s4 [3][3];
	out_item_t               res_s5;

	// stage 3 and 5 combinational
	logic signed [AccW-1:0]  acc3 [3], sum3 [3];
	logic signed [VehPW-1:0] vp_c [3];
	logic                    vovf_c;
	logic signed [SW-1:0]    acc5 [3], sum5 [3];
	logic signed [PosW-1:0]  w_c [3];
	logic                    wovf_c;

	// config write decode
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				rot_row_q[i] <= RowW'(1) << (COEF_FRAC_BITS + CoefW * i);
				cam_off_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgRotRow0: rot_row_q[0] <= cfg_data;
				CfgRotRow1: rot_row_q[1] <= cfg_data;
				CfgRotRow2: rot_row_q[2] <= cfg_data;
				CfgCamOffX: cam_off_q[0] <= cfg_data[PosW-1:0];
				CfgCamOffY: cam_off_q[1] <= cfg_data[PosW-1:0];
				CfgCamOffZ: cam_off_q[2] <= cfg_data[PosW-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en.en_s5 = !v_s5 || !out_stall;
		en.en_s4 = !v_s4 || en.en_s5;
		en.en_s3 = !v_s3 || en.en_s4;
		en.en_s2 = !v_s2 || en.en_s3;
		en.en_s1 = !v_s1 || en.en_s2;
	end

	assign in_stall = !en.en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= in_valid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en.en_s4) v_s4 <= v_s3;
			if (en.en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: camera point with vehicle z removed
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			cam_s1[0] <= CamW'(in_data.marker_x);
			cam_s1[1] <= CamW'(in_data.marker_y);
			cam_s1[2] <= CamW'(in_data.marker_z) - CamW'(in_data.veh_z);
			veh_s1[0] <= in_data.veh_x;
			veh_s1[1] <= in_data.veh_y;
			veh_s1[2] <= in_data.veh_z;
		end
	end

	// quaternion matrix, aligned with stage 2
	cptw_quat_mat #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_quat_mat (
		.clk  (clk),
		.en   (en),
		.qw   (in_data.quat_w),
		.qx   (in_data.quat_x),
		.qy   (in_data.quat_y),
		.qz   (in_data.quat_z),
		.r_s2 (r_s2)
	);

	// stage 2: mounting matrix products
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s2[i][j] <= $signed(rot_row_q[i][CoefW*j +: CoefW]) * cam_s1[j];
				end
				veh_s2[i] <= veh_s1[i];
			end
		end
	end

	// stage 3 logic: row sums, rounding, offset, clamp
	always_comb begin
		vovf_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc3[i] = AccW'(mp_s2[i][0]) + AccW'(mp_s2[i][1]) + AccW'(mp_s2[i][2]);
			sum3[i] = ((acc3[i] + AHalf) >>> COEF_FRAC_BITS) + AccW'(cam_off_q[i]);
			if (sum3[i] > VHi) begin
				vp_c[i] = VHi[VehPW-1:0];
				vovf_c  = 1'b1;
			end else if (sum3[i] < VLo) begin
				vp_c[i] = VLo[VehPW-1:0];
				vovf_c  = 1'b1;
			end else begin
				vp_c[i] = sum3[i][VehPW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			for (int i = 0; i < 3; i++) begin
				vp_s3[i]  <= vp_c[i];
				veh_s3[i] <= veh_s2[i];
			end
			r_s3    <= r_s2;
			vovf_s3 <= vovf_c;
		end
	end

	// stage 4: world rotation products
	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rp_s4[i][j] <= $signed(r_s3[3*i+j]) * vp_s3[j];
				end
				veh_s4[i] <= veh_s3[i];
			end
			vovf_s4 <= vovf_s3;
		end
	end

	// stage 5 logic: row sums, rounding, vehicle position, saturation
	always_comb begin
		wovf_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc5[i] = SW'(rp_s4[i][0]) + SW'(rp_s4[i][1]) + SW'(rp_s4[i][2]);
			sum5[i] = ((acc5[i] + SHalf) >>> COEF_FRAC_BITS) + SW'(veh_s4[i]);
			if (sum5[i] > WHi) begin
				w_c[i] = WHi[PosW-1:0];
				wovf_c = 1'b1;
			end else if (sum5[i] < WLo) begin
				w_c[i] = WLo[PosW-1:0];
				wovf_c = 1'b1;
			end else begin
				w_c[i] = sum5[i][PosW-1:0];
			end
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			res_s5.world_x  <= w_c[0];
			res_s5.world_y  <= w_c[1];
			res_s5.world_z  <= w_c[2];
			res_s5.overflow <= wovf_c || vovf_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

	// checks
`include "camera_point_to_world_frame_unit_assert.svh"
	`CPTW_ASSERT_NOW(a_free_when_out_empty, !out_valid, !in_stall,
		"input stalled while output stage empty")
	`CPTW_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v_s1,
		"accepted request missing from stage 1")
	`CPTW_ASSERT_NEXT(a_s4_moves_to_out, v_s4 && !out_stall, out_valid,
		"stage 4 request lost on way to output")

endmodule
